### hw/rtl/socv_pkg.sv
// Shared types and constants of the OR convolution core.
`timescale 1ns / 1ps

package socv_pkg;

   localparam int INDEX_W  = 10;
   localparam int VALUE_W  = 16;
   localparam int RESULT_W = 52;
   localparam int LOG_W    = 4;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_READ = 1'b1;

   typedef struct packed {
      logic               command;
      logic [INDEX_W-1:0] index;
      logic [VALUE_W-1:0] a_value;
      logic [VALUE_W-1:0] b_value;
      logic               last;
   } req_payload_type;

   typedef struct packed {
      logic [INDEX_W-1:0]  result_index;
      logic [RESULT_W-1:0] result_value;
   } rsp_payload_type;

endpackage

### hw/rtl/socv_if.sv
// Valid/ready channel interfaces for request and response beats.
`timescale 1ns / 1ps

interface socv_req_if import socv_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface socv_rsp_if import socv_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/socv_ram.sv
// Generic single-write, dual-read RAM with registered read data.
`timescale 1ns / 1ps

module socv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

### hw/rtl/subset_or_convolution_core.sv
// Top level of the OR (subset) convolution core: loads, transforms, reads.
//
//  channel  | dir | handshake              | beat contents
//  ---------+-----+------------------------+-------------------------------------------
//  req_bus  | in  | valid/ready            | command, index, a_value, b_value, last
//  rsp_bus  | out | valid/ready            | result_index, result_value
//  csr      | in  | APB, pready tied high  | log_size at byte address 0
//
// A load is written into the AB store as it is accepted; a read passes through the RAM read, then the output register.
// A load marked last runs L zeta passes, a product pass and L Mobius passes,
// for L = log_size; each store has a single write port.
// Reset clears control state only; stores need no clearing pass.
// req_bus.ready is low while a computation or a read is in progress; a read
// waits in place while the response register is full.
`timescale 1ns / 1ps

module subset_or_convolution_core import socv_pkg::*; #(
   parameter int MAX_LOG_SIZE = 10
) (
   input  logic              clock,
   input  logic              reset,
   socv_req_if.sink          req_bus,
   socv_rsp_if.source        rsp_bus,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   localparam int AW        = MAX_LOG_SIZE;
   localparam int DEPTH     = 1 << AW;
   localparam int SW        = VALUE_W + MAX_LOG_SIZE;
   localparam int PW        = 2 * SW;
   localparam int BW        = $clog2(MAX_LOG_SIZE + 1);
   localparam int XW        = (AW > INDEX_W) ? AW : INDEX_W;
   localparam int LOG_RESET = (MAX_LOG_SIZE < 10) ? MAX_LOG_SIZE : 10;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_READ     = 3'd1;
   localparam logic [2:0] ST_ZETA     = 3'd2;
   localparam logic [2:0] ST_ZETA_END = 3'd3;
   localparam logic [2:0] ST_PROD     = 3'd4;
   localparam logic [2:0] ST_PROD_END = 3'd5;
   localparam logic [2:0] ST_MOB      = 3'd6;
   localparam logic [2:0] ST_MOB_END  = 3'd7;

   localparam logic [1:0] OP_ZETA = 2'd0;
   localparam logic [1:0] OP_PROD = 2'd1;
   localparam logic [1:0] OP_MOB  = 2'd2;

   logic [BW-1:0]       log_ff, log_in;
   logic [2:0]          state_ff, state_in;
   logic [BW-1:0]       pass_ff, pass_in;
   logic [AW-1:0]       cnt_ff, cnt_in;
   logic                result_ready_ff, result_ready_in;

   logic                s1_valid_ff, s1_valid_in;
   logic [1:0]          s1_op_ff, s1_op_in;
   logic [AW-1:0]       s1_addr_ff, s1_addr_in;
   logic                s2_valid_ff, s2_valid_in;
   logic [AW-1:0]       s2_addr_ff;
   logic [PW-1:0]       prod_ff;

   logic [AW-1:0]       rd_addr_ff, rd_addr_in;
   logic [INDEX_W-1:0]  rd_idx_ff, rd_idx_in;

   logic                rsp_valid_ff, rsp_valid_in;
   rsp_payload_type     rsp_data_ff;

   logic [AW-1:0]       len_mask, half_last, bit_mask, low_mask;
   logic [AW-1:0]       pair_hi, pair_lo, req_addr;
   logic [XW-1:0]       req_idx_ext;
   logic [INDEX_W-1:0]  idx_mask;
   logic                req_fire, csr_write, last_pass, rsp_load;

   logic                ab_wr_en;
   logic [AW-1:0]       ab_wr_addr, ab_rd_addr_a;
   logic [2*SW-1:0]     ab_wr_data, ab_rd_a, ab_rd_b;
   logic [SW-1:0]       sum_a, sum_b;

   logic                res_wr_en;
   logic [AW-1:0]       res_wr_addr, res_rd_addr_a;
   logic [RESULT_W-1:0] res_wr_data, res_rd_a, res_rd_b;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == 1'b0) ? 32'(log_ff) : 32'd0;

   always_comb begin
      log_in = log_ff;
      if (csr_write && paddr[2] == 1'b0) begin
         log_in = ((5'(pwdata[LOG_W-1:0])) > 5'(MAX_LOG_SIZE))
                  ? BW'(MAX_LOG_SIZE) : BW'(pwdata[LOG_W-1:0]);
      end
   end

   // ---------------- address generation ----------------
   assign len_mask    = ~({AW{1'b1}} << log_ff);
   assign half_last   = len_mask >> 1;
   assign idx_mask    = ~({INDEX_W{1'b1}} << log_ff);
   assign req_idx_ext = XW'(req_bus.payload.index);
   assign req_addr    = AW'(req_idx_ext) & len_mask;
   assign bit_mask    = AW'(1) << pass_ff;
   assign low_mask    = bit_mask - AW'(1);
   assign pair_hi     = ((cnt_ff & ~low_mask) << 1) | bit_mask | (cnt_ff & low_mask);
   assign pair_lo     = pair_hi & ~bit_mask;
   assign last_pass   = (BW'(pass_ff + 1'b1) == log_ff);

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign rsp_load      = (state_ff == ST_READ) && (!rsp_valid_ff || rsp_bus.ready);

   // ---------------- sequencer ----------------
   always_comb begin
      state_in        = state_ff;
      pass_in         = pass_ff;
      cnt_in          = cnt_ff;
      result_ready_in = result_ready_ff;
      s1_valid_in     = 1'b0;
      s1_op_in        = s1_op_ff;
      s1_addr_in      = s1_addr_ff;
      rd_addr_in      = rd_addr_ff;
      rd_idx_in       = rd_idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rd_addr_in = req_addr;
               rd_idx_in  = req_bus.payload.index & idx_mask;
               pass_in    = '0;
               cnt_in     = '0;
               if (req_bus.payload.command == CMD_READ) begin
                  state_in = ST_READ;
               end else if (req_bus.payload.last) begin
                  state_in = (log_ff == '0) ? ST_PROD : ST_ZETA;
               end
            end
         end
         ST_READ: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         ST_ZETA: begin
            s1_valid_in = 1'b1;
            s1_op_in    = OP_ZETA;
            s1_addr_in  = pair_hi;
            cnt_in      = cnt_ff + AW'(1);
            if (cnt_ff == half_last) begin
               state_in = ST_ZETA_END;
            end
         end
         ST_ZETA_END: begin
            if (!s1_valid_ff) begin
               cnt_in = '0;
               if (last_pass) begin
                  pass_in  = '0;
                  state_in = ST_PROD;
               end else begin
                  pass_in  = pass_ff + 1'b1;
                  state_in = ST_ZETA;
               end
            end
         end
         ST_PROD: begin
            s1_valid_in = 1'b1;
            s1_op_in    = OP_PROD;
            s1_addr_in  = cnt_ff;
            cnt_in      = cnt_ff + AW'(1);
            if (cnt_ff == len_mask) begin
               state_in = ST_PROD_END;
            end
         end
         ST_PROD_END: begin
            if (!s1_valid_ff && !s2_valid_ff) begin
               cnt_in  = '0;
               pass_in = '0;
               if (log_ff == '0) begin
                  result_ready_in = 1'b1;
                  state_in        = ST_IDLE;
               end else begin
                  state_in = ST_MOB;
               end
            end
         end
         ST_MOB: begin
            s1_valid_in = 1'b1;
            s1_op_in    = OP_MOB;
            s1_addr_in  = pair_hi;
            cnt_in      = cnt_ff + AW'(1);
            if (cnt_ff == half_last) begin
               state_in = ST_MOB_END;
            end
         end
         ST_MOB_END: begin
            if (!s1_valid_ff) begin
               cnt_in = '0;
               if (last_pass) begin
                  result_ready_in = 1'b1;
                  state_in        = ST_IDLE;
               end else begin
                  pass_in  = pass_ff + 1'b1;
                  state_in = ST_MOB;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------- datapath arithmetic ----------------
   assign sum_a = ab_rd_a[2*SW-1:SW] + ab_rd_b[2*SW-1:SW];
   assign sum_b = ab_rd_a[SW-1:0] + ab_rd_b[SW-1:0];

   assign s2_valid_in = s1_valid_ff && (s1_op_ff == OP_PROD);

   // AB store: loads while idle, zeta write-back while computing
   always_comb begin
      ab_wr_en   = 1'b0;
      ab_wr_addr = req_addr;
      ab_wr_data = {SW'(req_bus.payload.a_value), SW'(req_bus.payload.b_value)};
      priority if (req_fire && req_bus.payload.command == CMD_LOAD) begin
         ab_wr_en = 1'b1;
      end else if (s1_valid_ff && s1_op_ff == OP_ZETA) begin
         ab_wr_en   = 1'b1;
         ab_wr_addr = s1_addr_ff;
         ab_wr_data = {sum_a, sum_b};
      end else begin
         ab_wr_en = 1'b0;
      end
   end

   assign ab_rd_addr_a = (state_ff == ST_PROD) ? cnt_ff : pair_hi;

   // Result store: product write-back or Mobius write-back
   always_comb begin
      res_wr_en   = 1'b0;
      res_wr_addr = s2_addr_ff;
      res_wr_data = RESULT_W'(prod_ff);
      priority if (s2_valid_ff) begin
         res_wr_en = 1'b1;
      end else if (s1_valid_ff && s1_op_ff == OP_MOB) begin
         res_wr_en   = 1'b1;
         res_wr_addr = s1_addr_ff;
         res_wr_data = res_rd_a - res_rd_b;
      end else begin
         res_wr_en = 1'b0;
      end
   end

   always_comb begin
      unique case (state_ff)
         ST_IDLE: res_rd_addr_a = req_addr;
         ST_READ: res_rd_addr_a = rd_addr_ff;
         default: res_rd_addr_a = pair_hi;
      endcase
   end

   socv_ram #(
      .WIDTH (2 * SW),
      .DEPTH (DEPTH)
   ) u_ab_ram (
      .clock     (clock),
      .wr_en     (ab_wr_en),
      .wr_addr   (ab_wr_addr),
      .wr_data   (ab_wr_data),
      .rd_addr_a (ab_rd_addr_a),
      .rd_data_a (ab_rd_a),
      .rd_addr_b (pair_lo),
      .rd_data_b (ab_rd_b)
   );

   socv_ram #(
      .WIDTH (RESULT_W),
      .DEPTH (DEPTH)
   ) u_res_ram (
      .clock     (clock),
      .wr_en     (res_wr_en),
      .wr_addr   (res_wr_addr),
      .wr_data   (res_wr_data),
      .rd_addr_a (res_rd_addr_a),
      .rd_data_a (res_rd_a),
      .rd_addr_b (pair_lo),
      .rd_data_b (res_rd_b)
   );

   // ---------------- response register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_data_ff;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         log_ff          <= BW'(LOG_RESET);
         state_ff        <= ST_IDLE;
         pass_ff         <= '0;
         cnt_ff          <= '0;
         result_ready_ff <= 1'b0;
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         log_ff          <= log_in;
         state_ff        <= state_in;
         pass_ff         <= pass_in;
         cnt_ff          <= cnt_in;
         result_ready_ff <= result_ready_in;
         s1_valid_ff     <= s1_valid_in;
         s2_valid_ff     <= s2_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff   <= s1_op_in;
      s1_addr_ff <= s1_addr_in;
      s2_addr_ff <= s1_addr_ff;
      prod_ff    <= ab_rd_a[2*SW-1:SW] * ab_rd_a[SW-1:0];
      rd_addr_ff <= rd_addr_in;
      rd_idx_ff  <= rd_idx_in;
      if (rsp_load) begin
         rsp_data_ff.result_index <= rd_idx_ff;
         rsp_data_ff.result_value <= result_ready_ff ? res_rd_a : '0;
      end
   end

   // ---------------- assertions ----------------
   a_s2_from_prod: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> $past(s1_op_ff) == OP_PROD)
      else $error("product write-back without a product beat");

   a_res_one_writer: assert property (@(posedge clock) disable iff (reset)
      !(s2_valid_ff && s1_valid_ff && s1_op_ff == OP_MOB))
      else $error("product and Mobius write-backs collide");

   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(state_ff) == ST_READ)
      else $error("response beat not caused by a read");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(result_ready_ff) |-> state_ff == ST_IDLE)
      else $error("result marked ready while still computing");

endmodule
